### hw/rtl/prd_pkg.sv
// Package for the packet route decision block: field widths, codes and types.
// Used by prd_ctrl, prd_datapath and packet_route_decision.
package prd_pkg;
    localparam int NumIfaces = 8;
    localparam int LinkW = 32;
    localparam int TableDepth = 256;
    localparam int IdxW = $clog2(TableDepth);
    localparam int EntryW = 3 + 8 + LinkW;

    localparam logic [1:0] CMD_ROUTE = 2'd0;
    localparam logic [1:0] CMD_SET = 2'd1;
    localparam logic [1:0] CMD_DEL = 2'd2;

    localparam logic [2:0] ACT_DUMP = 3'd0;
    localparam logic [2:0] ACT_SEND = 3'd1;
    localparam logic [2:0] ACT_SVC = 3'd2;
    localparam logic [2:0] ACT_MGMT = 3'd3;
    localparam logic [2:0] ACT_TABLE = 3'd4;

    localparam logic [7:0] ADDR_NONE = 8'd0;
    localparam logic [7:0] ADDR_DEBUG = 8'd1;
    localparam logic [2:0] IF_LOOP = 3'd0;
    localparam logic [2:0] IF_DEBUG = 3'd1;
    localparam logic [7:0] SVC_NONE = 8'd0;
    localparam logic [7:0] SVC_NETMAN = 8'd1;

    localparam logic [2:0] REG_NODE = 3'd0;
    localparam logic [2:0] REG_HUB = 3'd1;
    localparam logic [2:0] REG_NOROUTE = 3'd2;
    localparam logic [2:0] REG_LEARN = 3'd3;
    localparam logic [2:0] REG_BMASK = 3'd4;
    localparam logic [2:0] REG_PRESENT = 3'd5;

    typedef struct packed {
        logic       load;
        logic       lookup;
        logic       decide;
        logic       emit;
        logic       advance;
    } prd_cmd_t;

    typedef struct packed {
        logic       more;
    } prd_status_t;
endpackage

### hw/rtl/prd_ctrl.sv
// Controller for the packet route decision block.
// Depends on prd_pkg.
module prd_ctrl import prd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  prd_status_t status,
    output prd_cmd_t    cmd
);
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_LOOK   = 4'b0010,
        ST_DECIDE = 4'b0100,
        ST_OUT    = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                cmd.lookup = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                m_tvalid = 1'b1;
                cmd.emit = 1'b1;
                if (m_tready) begin
                    cmd.advance = 1'b1;
                    if (!status.more) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

### hw/rtl/prd_datapath.sv
// Datapath for the packet route decision block: registers, route table, decision.
// Depends on prd_pkg.
module prd_datapath import prd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    input  logic [2:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    input  logic [79:0]       s_tdata,
    input  prd_cmd_t          cmd,
    output prd_status_t       status,
    output logic [71:0]       m_tdata,
    output logic              m_tlast
);
    logic [7:0] node_reg, bmask_reg, present_reg;
    logic       hub_reg, noroute_reg, learn_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_reg <= 8'd1;
            hub_reg <= 1'b0;
            noroute_reg <= 1'b0;
            learn_reg <= 1'b0;
            bmask_reg <= 8'd0;
            present_reg <= 8'd3;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_NODE:    node_reg <= cfg_data;
                REG_HUB:     hub_reg <= cfg_data[0];
                REG_NOROUTE: noroute_reg <= cfg_data[0];
                REG_LEARN:   learn_reg <= cfg_data[0];
                REG_BMASK:   bmask_reg <= cfg_data;
                REG_PRESENT: present_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input word
    logic [1:0]       c_reg;
    logic [7:0]       src_reg, dst_reg, hops_reg, dsvc_reg, ssvc_reg;
    logic [2:0]       inif_reg;
    logic [LinkW-1:0] link_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            c_reg <= s_tdata[1:0];
            src_reg <= s_tdata[9:2];
            dst_reg <= s_tdata[17:10];
            inif_reg <= s_tdata[20:18];
            hops_reg <= s_tdata[28:21];
            link_reg <= s_tdata[60:29];
            dsvc_reg <= s_tdata[68:61];
            ssvc_reg <= s_tdata[76:69];
        end
    end

    // effective destination after rewrites
    logic [7:0] dst1, src_o, dst_o;
    logic       fwd_dbg, is_local, go_send, go_dlv, drop_self;
    always_comb begin
        dst1 = (src_reg == ADDR_DEBUG && dst_reg == ADDR_NONE) ? node_reg : dst_reg;
        is_local = (dst1 == node_reg);
        fwd_dbg = (src_reg == ADDR_DEBUG) && (ssvc_reg == SVC_NONE);
        drop_self = (src_reg == node_reg) && (inif_reg != IF_LOOP);
        src_o = (!is_local && fwd_dbg) ? node_reg : src_reg;
        dst_o = (is_local && dsvc_reg == SVC_NONE) ? ADDR_DEBUG : dst1;
        go_send = is_local ? (!drop_self && dsvc_reg == SVC_NONE) : (fwd_dbg || hub_reg);
        go_dlv = is_local && !drop_self && dsvc_reg != SVC_NONE;
    end

    // route table: valid bits in flops, entries in memory
    logic [TableDepth-1:0] valid_reg;
    logic [EntryW-1:0]     mem [TableDepth];
    logic [EntryW-1:0]     rd_reg;
    logic                  dvalid_reg, lhit_reg;
    logic                  learn_now;

    assign learn_now = (c_reg == CMD_ROUTE) && learn_reg && (src_reg != ADDR_DEBUG)
                       && (src_reg != node_reg) && !valid_reg[src_reg];

    always_ff @(posedge aclk) begin
        if (cmd.lookup) begin
            rd_reg <= mem[dst_o[IdxW-1:0]];
        end
        if (cmd.load) begin
            if (s_tdata[1:0] == CMD_SET) begin
                mem[s_tdata[10 +: IdxW]] <= {s_tdata[20:18], s_tdata[28:21], s_tdata[60:29]};
            end
        end else if (cmd.lookup && learn_now) begin
            mem[src_reg[IdxW-1:0]] <= {inif_reg, hops_reg, link_reg};
        end
    end

    // a route learned for the source is visible to the lookup of the same word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.lookup) begin
            dvalid_reg <= valid_reg[dst_o] || (learn_now && (dst_o == src_reg));
            lhit_reg <= learn_now && (dst_o == src_reg);
            if (c_reg == CMD_SET) begin
                valid_reg[dst_reg] <= 1'b1;
            end else if (c_reg == CMD_DEL) begin
                valid_reg[dst_reg] <= 1'b0;
            end else if (learn_now) begin
                valid_reg[src_reg] <= 1'b1;
            end
        end
    end

    // decision
    logic [7:0]       cand_reg;
    logic [2:0]       act_reg, oif_reg;
    logic [LinkW-1:0] olink_reg;
    logic             bcast_reg;
    logic [7:0]       hops1;
    assign hops1 = hops_reg + 8'd1;

    logic [EntryW-1:0] entry;
    logic [2:0]       r_if;
    logic [LinkW-1:0] r_link;
    logic             r_hit, ok;
    logic [7:0]       cand0, cand;
    logic [2:0]       pick;
    logic             have;

    always_comb begin
        r_hit = 1'b1;
        entry = lhit_reg ? {inif_reg, hops_reg, link_reg} : rd_reg;
        r_if = entry[EntryW-1 -: 3];
        r_link = entry[LinkW-1:0];
        if (dst_o == ADDR_DEBUG) begin
            r_if = IF_DEBUG;
            r_link = '0;
        end else if (dst_o == node_reg) begin
            r_if = IF_LOOP;
            r_link = '0;
        end else begin
            r_hit = dvalid_reg;
        end
        ok = !((src_o != node_reg) && (inif_reg == r_if))
             && !((r_if == IF_LOOP) && (dst_o != node_reg))
             && present_reg[r_if];
        cand0 = ((bmask_reg == 8'd0) ? present_reg : bmask_reg) & present_reg;
        cand0[0] = 1'b0;
        cand0[inif_reg] = 1'b0;
    end

    always_comb begin
        cand = cmd.decide ? cand0 : cand_reg;
        have = 1'b0;
        pick = '0;
        for (int i = NumIfaces - 1; i >= 0; i--) begin
            if (cand[i]) begin
                have = 1'b1;
                pick = 3'(i);
            end
        end
    end

    logic [7:0] rest;
    always_comb begin
        rest = cand;
        rest[pick] = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (cmd.decide) begin
            bcast_reg <= 1'b0;
            oif_reg <= '0;
            olink_reg <= '0;
            act_reg <= ACT_DUMP;
            cand_reg <= '0;
            if (c_reg == CMD_SET || c_reg == CMD_DEL) begin
                act_reg <= ACT_TABLE;
            end else if (c_reg == CMD_ROUTE) begin
                if (go_dlv) begin
                    act_reg <= (dsvc_reg == SVC_NETMAN) ? ACT_MGMT : ACT_SVC;
                end else if (go_send) begin
                    if (r_hit) begin
                        if (ok) begin
                            act_reg <= ACT_SEND;
                            oif_reg <= r_if;
                            olink_reg <= r_link;
                        end
                    end else if (noroute_reg && have) begin
                        act_reg <= ACT_SEND;
                        bcast_reg <= 1'b1;
                        oif_reg <= pick;
                        cand_reg <= rest;
                    end
                end
            end
        end else if (cmd.advance) begin
            oif_reg <= pick;
            cand_reg <= rest;
        end
    end

    assign status.more = bcast_reg && (cand_reg != 8'd0);

    logic dl, sd, nz;
    always_comb begin
        sd = (act_reg == ACT_SEND);
        dl = (act_reg == ACT_SVC) || (act_reg == ACT_MGMT);
        nz = sd || dl;
        m_tdata = '0;
        m_tdata[2:0] = act_reg;
        m_tdata[5:3] = oif_reg;
        m_tdata[13:6] = nz ? src_o : 8'd0;
        m_tdata[21:14] = nz ? dst_o : 8'd0;
        m_tdata[29:22] = sd ? hops1 : (dl ? hops_reg : 8'd0);
        m_tdata[61:30] = olink_reg;
        m_tdata[69:62] = dl ? dsvc_reg : 8'd0;
        m_tlast = !status.more;
    end
endmodule

### hw/rtl/packet_route_decision.sv
// Top level of the packet route decision block.
// Depends on prd_pkg, prd_ctrl and prd_datapath.
//
// channel  dir  contents
// s_       in   tdata: cmd, src_addr, dst_addr, in_iface, hop_count, link_addr,
//                      dst_service, src_service
// m_       out  tdata: action, out_iface, out_src_addr, out_dst_addr, out_hops,
//                      out_link_addr, out_service; tlast: last
// cfg_     in   cfg_index, cfg_data
//
// An item passes the states idle (load), look (table read), decide and out;
// a broadcast item gives one result word per candidate interface, up to 7.
// Synchronous active-low reset clears state, config registers and route valid bits.
// A stalled result word holds until taken; no new word is taken meanwhile.
module packet_route_decision import prd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // cmd, src_addr, dst_addr, in_iface, hop_count, link_addr, dst_service,
    // src_service from bit 0 up
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // action, out_iface, out_src_addr, out_dst_addr, out_hops, out_link_addr,
    // out_service from bit 0 up
    output logic [71:0] m_tdata,
    output logic        m_tlast
);
    prd_cmd_t    cmd;
    prd_status_t status;

    assign cfg_ready = 1'b1;

    prd_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .status(status), .cmd(cmd)
    );

    prd_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .s_tdata(s_tdata), .cmd(cmd), .status(status),
        .m_tdata(m_tdata), .m_tlast(m_tlast)
    );
endmodule

### sim/tb_packet_route_decision.sv
// Testbench for packet_route_decision: drives header words and table commands,
// predicts each result word in a scoreboard class and checks it. Needs prd_pkg.
module tb_packet_route_decision;
    import prd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  cmd;
        logic [7:0]  src;
        logic [7:0]  dst;
        logic [2:0]  ifc;
        logic [7:0]  hops;
        logic [31:0] link;
        logic [7:0]  dsvc;
        logic [7:0]  ssvc;
    } hdr_t;

    typedef struct {
        logic [2:0]  act;
        logic [2:0]  ifc;
        logic [7:0]  src;
        logic [7:0]  dst;
        logic [7:0]  hops;
        logic [31:0] link;
        logic [7:0]  svc;
        logic        last;
    } word_t;

    class route_scoreboard;
        logic [7:0]  node_addr;
        logic        is_hub, bcast_on_miss, learn_on;
        logic [7:0]  bmask, present;
        logic        entry_ok[TableDepth];
        logic [2:0]  entry_if[TableDepth];
        logic [31:0] entry_link[TableDepth];
        word_t       pending_words[$];
        word_t       item_words[$];
        int          errors;

        function new();
            node_addr = 8'd1; is_hub = 0; bcast_on_miss = 0; learn_on = 0;
            bmask = 8'd0; present = 8'd3; errors = 0;
            foreach (entry_ok[i]) entry_ok[i] = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [7:0] val);
            case (idx)
                REG_NODE:    node_addr = val;
                REG_HUB:     is_hub = val[0];
                REG_NOROUTE: bcast_on_miss = val[0];
                REG_LEARN:   learn_on = val[0];
                REG_BMASK:   bmask = val;
                REG_PRESENT: present = val;
                default: ;
            endcase
        endfunction

        function void add(logic [2:0] act, logic [2:0] ifc, logic [7:0] src, logic [7:0] dst,
                          logic [7:0] hops, logic [31:0] link, logic [7:0] svc);
            word_t w;
            w = '{act, ifc, src, dst, hops, link, svc, 1'b0};
            item_words.push_back(w);
        endfunction

        function bit lookup(logic [7:0] a, output logic [2:0] ifc, output logic [31:0] link);
            link = '0;
            ifc = '0;
            if (a == ADDR_DEBUG) begin
                ifc = IF_DEBUG;
                return 1;
            end
            if (a == node_addr) begin
                ifc = IF_LOOP;
                return 1;
            end
            if (entry_ok[a]) begin
                ifc = entry_if[a];
                link = entry_link[a];
                return 1;
            end
            return 0;
        endfunction

        function void forward(logic [7:0] src, logic [7:0] dst, logic [2:0] in_if,
                              logic [7:0] hops);
            logic [2:0]  ifc;
            logic [31:0] link;
            logic [7:0]  cand;
            hops = hops + 8'd1;
            if (!lookup(dst, ifc, link)) begin
                if (!bcast_on_miss) return;
                cand = (bmask == 0) ? present : bmask;
                for (int i = 0; i < 8; i++) begin
                    if (cand[i] && i != in_if && i != IF_LOOP && present[i])
                        add(ACT_SEND, 3'(i), src, dst, hops, 32'd0, 8'd0);
                end
                return;
            end
            if (src != node_addr && in_if == ifc) return;
            if (ifc == IF_LOOP && dst != node_addr) return;
            if (!present[ifc]) return;
            add(ACT_SEND, ifc, src, dst, hops, link, 8'd0);
        endfunction

        function void decide_packet(hdr_t h);
            logic [2:0]  ri;
            logic [31:0] rl;
            logic [7:0]  src, dst;
            src = h.src;
            dst = h.dst;
            item_words.delete();
            if (h.cmd == CMD_SET || h.cmd == CMD_DEL) begin
                if (h.cmd == CMD_SET) begin
                    entry_if[dst] = h.ifc;
                    entry_link[dst] = h.link;
                    entry_ok[dst] = 1;
                end else begin
                    entry_ok[dst] = 0;
                end
                add(ACT_TABLE, 0, 0, 0, 0, 0, 0);
            end else if (h.cmd == CMD_ROUTE) begin
                if (learn_on && !lookup(src, ri, rl)) begin
                    entry_if[src] = h.ifc;
                    entry_link[src] = h.link;
                    entry_ok[src] = 1;
                end
                if (src == ADDR_DEBUG && dst == ADDR_NONE) dst = node_addr;
                if (dst != node_addr) begin
                    if (src == ADDR_DEBUG && h.ssvc == SVC_NONE)
                        forward(node_addr, dst, h.ifc, h.hops);
                    else if (is_hub)
                        forward(src, dst, h.ifc, h.hops);
                end else if (!(src == node_addr && h.ifc != IF_LOOP)) begin
                    if (h.dsvc == SVC_NONE)
                        forward(src, ADDR_DEBUG, h.ifc, h.hops);
                    else if (h.dsvc == SVC_NETMAN)
                        add(ACT_MGMT, 0, src, dst, h.hops, 0, h.dsvc);
                    else
                        add(ACT_SVC, 0, src, dst, h.hops, 0, h.dsvc);
                end
            end
            if (item_words.size() == 0) add(ACT_DUMP, 0, 0, 0, 0, 0, 0);
            item_words[item_words.size() - 1].last = 1;
            foreach (item_words[i]) pending_words.push_back(item_words[i]);
        endfunction

        task report(string msg);
            $display("mismatch @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_word(logic [71:0] d, logic tl);
            word_t e, g;
            g = '{d[2:0], d[5:3], d[13:6], d[21:14], d[29:22], d[61:30], d[69:62], tl};
            if (pending_words.size() == 0) begin
                report($sformatf("unexpected word %h last %b", d, tl));
                return;
            end
            e = pending_words.pop_front();
            if (g.act !== e.act) report($sformatf("action %0d exp %0d", g.act, e.act));
            if (g.ifc !== e.ifc) report($sformatf("iface %0d exp %0d", g.ifc, e.ifc));
            if (g.src !== e.src) report($sformatf("src %0d exp %0d", g.src, e.src));
            if (g.dst !== e.dst) report($sformatf("dst %0d exp %0d", g.dst, e.dst));
            if (g.hops !== e.hops) report($sformatf("hops %0d exp %0d", g.hops, e.hops));
            if (g.link !== e.link) report($sformatf("link %h exp %h", g.link, e.link));
            if (g.svc !== e.svc) report($sformatf("service %0d exp %0d", g.svc, e.svc));
            if (g.last !== e.last) report($sformatf("last %b exp %b", g.last, e.last));
        endtask
    endclass

    logic        aclk, aresetn;
    logic        cfg_valid, cfg_ready;
    logic [2:0]  cfg_index;
    logic [7:0]  cfg_data;
    logic        s_tvalid, s_tready;
    logic [79:0] s_tdata;
    logic        m_tvalid, m_tready;
    logic [71:0] m_tdata;
    logic        m_tlast;

    route_scoreboard sb = new();
    bit idle_on = 1;
    int stall_left = 0;

    packet_route_decision dut (.*);

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 3);
            m_tready <= 0;
        end else begin
            m_tready <= 1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_word(m_tdata, m_tlast);
    end

    task write_reg(logic [2:0] idx, logic [7:0] val);
        wait (sb.pending_words.size() == 0);
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    task setup(logic [7:0] node, bit hub, bit bc, bit learn, logic [7:0] bm, logic [7:0] pr);
        write_reg(REG_NODE, node);
        write_reg(REG_HUB, hub);
        write_reg(REG_NOROUTE, bc);
        write_reg(REG_LEARN, learn);
        write_reg(REG_BMASK, bm);
        write_reg(REG_PRESENT, pr);
    endtask

    task send_hdr(hdr_t h);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            @(negedge aclk);
            s_tvalid <= 0;
            repeat ($urandom_range(0, 3)) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1;
        s_tdata <= {3'b0, h.ssvc, h.dsvc, h.link, h.hops, h.ifc, h.dst, h.src, h.cmd};
        do @(posedge aclk); while (!s_tready);
        sb.decide_packet(h);
        @(negedge aclk);
        s_tvalid <= 0;
    endtask

    task hdr(logic [1:0] c, logic [7:0] s, logic [7:0] d, logic [2:0] i, logic [7:0] hp,
             logic [31:0] l, logic [7:0] ds, logic [7:0] ss);
        hdr_t h;
        h = '{c, s, d, i, hp, l, ds, ss};
        send_hdr(h);
    endtask

    function logic [7:0] pick_addr();
        case ($urandom_range(0, 5))
            0: return ADDR_NONE;
            1: return ADDR_DEBUG;
            2: return sb.node_addr;
            3, 4: return 8'($urandom_range(2, 12));
            default: return 8'($urandom);
        endcase
    endfunction

    function logic [7:0] pick_svc();
        case ($urandom_range(0, 3))
            0: return SVC_NONE;
            1: return SVC_NETMAN;
            default: return 8'($urandom);
        endcase
    endfunction

    task random_hdrs(int n);
        hdr_t h;
        int r;
        repeat (n) begin
            r = $urandom_range(0, 99);
            h.cmd = (r < 70) ? CMD_ROUTE : (r < 84) ? CMD_SET : (r < 96) ? CMD_DEL : CMD_UNUSED;
            h.src = pick_addr();
            h.dst = pick_addr();
            h.ifc = 3'($urandom);
            h.hops = 8'($urandom);
            h.link = $urandom;
            h.dsvc = pick_svc();
            h.ssvc = pick_svc();
            send_hdr(h);
        end
    endtask

    initial begin
        aresetn = 0;
        cfg_valid = 0; cfg_index = '0; cfg_data = '0;
        s_tvalid = 0; s_tdata = '0;
        m_tready = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        setup(8'd5, 1, 1, 1, 8'h00, 8'hFF);
        hdr(CMD_SET, 0, 10, 3, 7, 32'hFFFF_FFFF, 0, 0);
        hdr(CMD_ROUTE, 20, 10, 2, 4, 32'h1234_5678, 9, 9);
        hdr(CMD_ROUTE, 20, 10, 3, 4, 0, 9, 9);          // back out arrival port
        hdr(CMD_ROUTE, 30, 10, 2, 255, 0, 9, 9);        // hop count wraps
        hdr(CMD_ROUTE, 1, 0, 0, 2, 0, 0, 0);            // debug to no-address
        hdr(CMD_ROUTE, 7, 5, 0, 2, 0, 1, 3);            // management
        hdr(CMD_ROUTE, 7, 5, 0, 2, 0, 255, 3);          // service
        hdr(CMD_ROUTE, 5, 5, 2, 2, 0, 4, 4);            // own address off loopback
        hdr(CMD_ROUTE, 5, 5, 0, 2, 0, 4, 4);
        hdr(CMD_ROUTE, 9, 77, 4, 3, 0, 2, 2);           // broadcast
        hdr(CMD_ROUTE, 1, 88, 6, 3, 0, 2, 0);           // debug source rewritten
        hdr(CMD_DEL, 0, 10, 0, 0, 0, 0, 0);
        hdr(CMD_ROUTE, 20, 10, 2, 4, 0, 9, 9);
        hdr(CMD_SET, 0, 30, 0, 0, 32'hA5A5_A5A5, 0, 0);
        hdr(CMD_ROUTE, 20, 30, 2, 4, 0, 9, 9);          // loopback to other node
        hdr(CMD_UNUSED, 255, 255, 7, 255, 32'hFFFF_FFFF, 255, 255);
        hdr(CMD_SET, 255, 255, 7, 255, 32'hFFFF_FFFF, 255, 255);
        hdr(CMD_ROUTE, 255, 255, 7, 0, 0, 0, 255);

        setup(8'd0, 0, 1, 0, 8'hFF, 8'h00);
        hdr(CMD_ROUTE, 1, 99, 2, 0, 0, 0, 0);           // nothing present
        random_hdrs(18);
        setup(8'd255, 1, 0, 1, 8'h00, 8'hFF);
        random_hdrs(18);
        setup(8'd1, 1, 1, 1, 8'($urandom), 8'($urandom));
        random_hdrs(18);
        setup(8'($urandom_range(2, 12)), 1, 1, 0, 8'h00, 8'($urandom));
        random_hdrs(18);
        idle_on = 0;
        setup(8'd3, 1, 1, 1, 8'h00, 8'hFE);
        random_hdrs(18);

        @(negedge aclk);
        s_tvalid <= 0;
        wait (sb.pending_words.size() == 0);
        repeat (20) @(posedge aclk);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
